### design/wpd_pkg.sv
// Shared constants, codes and widths for the weighted patch distance block.
package wpd_pkg;

    localparam int COORD_W   = 8;
    localparam int COLOR_W   = 8;
    localparam int CFG_W     = 9;
    localparam int RAD_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int PIX_W     = 25;
    localparam int HOLE_BIT  = 24;
    localparam int SQ_W      = 18;
    localparam int DIST_W    = 18;
    localparam int SC_W      = 10;
    localparam int OFF_W     = RAD_W + 1;

    localparam int MAX_SQ       = 3 * 255 * 255;
    localparam int KNOWN_WEIGHT = 4;
    localparam int HOLE_WEIGHT  = 1;
    localparam int RAD_LIMIT    = (1 << RAD_W) - 1;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_RADIUS = 7;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 9'd256;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 9'd256;
    localparam logic [RAD_W-1:0] PATCH_RADIUS_RST = 3'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATCH_RADIUS = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_DIST  = 1'b1;

endpackage

### design/weighted_patch_distance_top.sv
// Top level of the weighted patch distance block: config registers, store, walker, divider.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+------------------------------------------
//  request   | start, busy (taken: !busy)   | op, target_col/row, source_col/row, rgb, hole
//  result    | done (one-cycle strobe)      | distance
//  config    | cfg_write                    | cfg_addr, cfg_data
//
// A write request leaves busy low. A distance request holds busy while the walker reads
// one store read pair per patch position and then empties its two-stage drain.
// The divider then yields one quotient bit per cycle (28 at the default MAX_RADIUS) and runs
// behind the next walk; a walk that ends before it is free waits in its drain state.
// done rises in the cycle after the last divide step. Reset clears control and config; the
// frame store is not cleared. The receiver cannot stall results.
module weighted_patch_distance_top #(
    parameter int MAX_WIDTH  = wpd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = wpd_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = wpd_pkg::DEF_MAX_RADIUS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          op,
    input  logic [wpd_pkg::COORD_W-1:0]   target_col,
    input  logic [wpd_pkg::COORD_W-1:0]   target_row,
    input  logic [wpd_pkg::COORD_W-1:0]   source_col,
    input  logic [wpd_pkg::COORD_W-1:0]   source_row,
    input  logic [wpd_pkg::COLOR_W-1:0]   red,
    input  logic [wpd_pkg::COLOR_W-1:0]   green,
    input  logic [wpd_pkg::COLOR_W-1:0]   blue,
    input  logic                          hole_mark,
    output logic                          done,
    output logic [wpd_pkg::DIST_W-1:0]    distance,
    input  logic                          cfg_write,
    input  logic [wpd_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [wpd_pkg::CFG_W-1:0]     cfg_data
);
    import wpd_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int RMAX   = (MAX_RADIUS < RAD_LIMIT) ? MAX_RADIUS : RAD_LIMIT;
    localparam int NPOS   = (2 * RMAX + 1) * (2 * RMAX + 1);
    localparam int WSUM_W = $clog2(NPOS * KNOWN_WEIGHT + 1);
    localparam int TOT_W  = $clog2(NPOS * KNOWN_WEIGHT * MAX_SQ + 1);

    localparam logic [ADDR_W-1:0] ROW_PITCH = ADDR_W'(MAX_WIDTH);

    logic [CFG_W-1:0]  frame_width_reg, frame_height_reg, w_eff, h_eff;
    logic [RAD_W-1:0]  patch_radius_reg;
    logic              accept, store_we, walk_req, rd_en, div_busy, div_start;
    logic [ADDR_W-1:0] waddr, addr_a, addr_b;
    logic [PIX_W-1:0]  rdata_a, rdata_b;
    logic [TOT_W-1:0]  total;
    logic [WSUM_W-1:0] weight;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            patch_radius_reg <= PATCH_RADIUS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_addr)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                CFG_PATCH_RADIUS: patch_radius_reg <= cfg_data[RAD_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        w_eff = frame_width_reg;
        if (frame_width_reg == '0)
            w_eff = CFG_W'(1);
        else if (int'(frame_width_reg) > MAX_WIDTH)
            w_eff = CFG_W'(MAX_WIDTH);
        h_eff = frame_height_reg;
        if (frame_height_reg == '0)
            h_eff = CFG_W'(1);
        else if (int'(frame_height_reg) > MAX_HEIGHT)
            h_eff = CFG_W'(MAX_HEIGHT);
    end

    assign accept   = start && !busy;
    assign store_we = accept && (op == OP_WRITE)
                      && (int'(target_col) < MAX_WIDTH) && (int'(target_row) < MAX_HEIGHT);
    assign walk_req = accept && (op == OP_DIST);
    assign waddr    = ADDR_W'(target_row) * ROW_PITCH + ADDR_W'(target_col);

    wpd_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .we      (store_we),
        .waddr   (waddr),
        .wdata   ({hole_mark, red, green, blue}),
        .rd_en   (rd_en),
        .raddr_a (addr_a),
        .raddr_b (addr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    wpd_walk #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS),
        .ADDR_W     (ADDR_W),
        .TOT_W      (TOT_W),
        .WSUM_W     (WSUM_W)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (walk_req),
        .tc        (target_col),
        .tr        (target_row),
        .sc        (source_col),
        .sr        (source_row),
        .w         (w_eff),
        .h         (h_eff),
        .radius    (patch_radius_reg),
        .busy      (busy),
        .rd_en     (rd_en),
        .addr_a    (addr_a),
        .addr_b    (addr_b),
        .rdata_a   (rdata_a),
        .rdata_b   (rdata_b),
        .div_busy  (div_busy),
        .div_start (div_start),
        .total     (total),
        .weight    (weight)
    );

    wpd_div #(
        .TOT_W  (TOT_W),
        .WSUM_W (WSUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (total),
        .divisor  (weight),
        .busy     (div_busy),
        .done     (done),
        .quotient (distance)
    );

endmodule

### design/wpd_store.sv
// Pixel frame store: one write port, two registered read ports.
module wpd_store #(
    parameter int DEPTH  = wpd_pkg::DEF_MAX_WIDTH * wpd_pkg::DEF_MAX_HEIGHT,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          waddr,
    input  logic [wpd_pkg::PIX_W-1:0]  wdata,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          raddr_a,
    input  logic [ADDR_W-1:0]          raddr_b,
    output logic [wpd_pkg::PIX_W-1:0]  rdata_a,
    output logic [wpd_pkg::PIX_W-1:0]  rdata_b
);
    import wpd_pkg::*;

    logic [PIX_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

### design/wpd_walk.sv
// Patch walker: address sequencer, squared difference stage and weighted accumulators.
module wpd_walk #(
    parameter int MAX_WIDTH  = wpd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = wpd_pkg::DEF_MAX_RADIUS,
    parameter int ADDR_W     = 16,
    parameter int TOT_W      = 28,
    parameter int WSUM_W     = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req,
    input  logic [wpd_pkg::COORD_W-1:0] tc,
    input  logic [wpd_pkg::COORD_W-1:0] tr,
    input  logic [wpd_pkg::COORD_W-1:0] sc,
    input  logic [wpd_pkg::COORD_W-1:0] sr,
    input  logic [wpd_pkg::CFG_W-1:0]   w,
    input  logic [wpd_pkg::CFG_W-1:0]   h,
    input  logic [wpd_pkg::RAD_W-1:0]   radius,
    output logic                        busy,
    output logic                        rd_en,
    output logic [ADDR_W-1:0]           addr_a,
    output logic [ADDR_W-1:0]           addr_b,
    input  logic [wpd_pkg::PIX_W-1:0]   rdata_a,
    input  logic [wpd_pkg::PIX_W-1:0]   rdata_b,
    input  logic                        div_busy,
    output logic                        div_start,
    output logic [TOT_W-1:0]            total,
    output logic [WSUM_W-1:0]           weight
);
    import wpd_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

    localparam logic [ADDR_W-1:0]      ROW_PITCH = ADDR_W'(MAX_WIDTH);
    localparam logic signed [SC_W-1:0] ONE_S     = SC_W'(1);

    state_t                  state_reg, state_next;
    logic signed [OFF_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [RAD_W-1:0]        r_reg, r_eff;
    logic [COORD_W-1:0]      tc_reg, tr_reg, sc_reg, sr_reg;
    logic                    v1_reg, v2_reg, ok1_reg, hole2_reg;
    logic [SQ_W-1:0]         sq2_reg, sq_val;
    logic [TOT_W-1:0]        total_reg;
    logic [WSUM_W-1:0]       weight_reg;

    logic signed [OFF_W-1:0] r_pos, r_neg_eff;
    logic                    last_col, last_pos, drained, src_ok;
    logic signed [SC_W-1:0]  tx_s, ty_s, sx_s, sy_s, w_s, h_s;
    logic [CFG_W-1:0]        tx, ty;

    function automatic logic signed [SC_W-1:0] ext_off(input logic signed [OFF_W-1:0] d);
        return {{(SC_W-OFF_W){d[OFF_W-1]}}, d};
    endfunction

    function automatic logic signed [SC_W-1:0] ext_coord(input logic [COORD_W-1:0] c);
        return {{(SC_W-COORD_W){1'b0}}, c};
    endfunction

    function automatic logic [CFG_W-1:0] clamp(input logic signed [SC_W-1:0] v,
                                               input logic signed [SC_W-1:0] hi);
        logic [CFG_W-1:0] res;
        if (v < 0)
            res = '0;
        else if (v > hi)
            res = hi[CFG_W-1:0];
        else
            res = v[CFG_W-1:0];
        return res;
    endfunction

    function automatic logic [SQ_W-1:0] sq_rgb(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
        logic [COLOR_W-1:0]   x, y, d;
        logic [2*COLOR_W-1:0] p;
        logic [SQ_W-1:0]      s;
        s = '0;
        for (int c = 0; c < 3; c++)
        begin
            x = a[c*COLOR_W +: COLOR_W];
            y = b[c*COLOR_W +: COLOR_W];
            d = (x > y) ? x - y : y - x;
            p = d * d;
            s = s + SQ_W'(p);
        end
        return s;
    endfunction

    always_comb
    begin
        r_eff = radius;
        if (int'(radius) > MAX_RADIUS)
        begin
            r_eff = RAD_W'(MAX_RADIUS);
        end
    end

    assign r_pos     = $signed({1'b0, r_reg});
    assign r_neg_eff = -$signed({1'b0, r_eff});
    assign last_col  = (dx_reg == r_pos);
    assign last_pos  = last_col && (dy_reg == r_pos);
    assign drained   = !v1_reg && !v2_reg;

    always_comb
    begin
        state_next = state_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req)
                begin
                    state_next = ST_RUN;
                    dx_next    = r_neg_eff;
                    dy_next    = r_neg_eff;
                end
            end
            ST_RUN:
            begin
                if (last_pos)
                begin
                    state_next = ST_DRAIN;
                end
                else if (last_col)
                begin
                    dx_next = -r_pos;
                    dy_next = dy_reg + OFF_W'(1);
                end
                else
                begin
                    dx_next = dx_reg + OFF_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (drained && !div_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // target clamps to the frame, source outside the frame reads black
    always_comb
    begin
        w_s    = $signed({{(SC_W-CFG_W){1'b0}}, w});
        h_s    = $signed({{(SC_W-CFG_W){1'b0}}, h});
        tx_s   = ext_coord(tc_reg) + ext_off(dx_reg);
        ty_s   = ext_coord(tr_reg) + ext_off(dy_reg);
        sx_s   = ext_coord(sc_reg) + ext_off(dx_reg);
        sy_s   = ext_coord(sr_reg) + ext_off(dy_reg);
        tx     = clamp(tx_s, w_s - ONE_S);
        ty     = clamp(ty_s, h_s - ONE_S);
        src_ok = !sx_s[SC_W-1] && (sx_s < w_s) && !sy_s[SC_W-1] && (sy_s < h_s);
    end

    assign rd_en  = (state_reg == ST_RUN);
    assign addr_a = ADDR_W'(ty) * ROW_PITCH + ADDR_W'(tx);
    assign addr_b = ADDR_W'(sy_s[CFG_W-1:0]) * ROW_PITCH + ADDR_W'(sx_s[CFG_W-1:0]);

    assign sq_val = sq_rgb(rdata_a, ok1_reg ? rdata_b : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dx_reg    <= '0;
            dy_reg    <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            v1_reg    <= rd_en;
            v2_reg    <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ok1_reg   <= src_ok;
        sq2_reg   <= sq_val;
        hole2_reg <= rdata_a[HOLE_BIT];
        if (state_reg == ST_IDLE && req)
        begin
            tc_reg     <= tc;
            tr_reg     <= tr;
            sc_reg     <= sc;
            sr_reg     <= sr;
            r_reg      <= r_eff;
            total_reg  <= '0;
            weight_reg <= '0;
        end
        else if (v2_reg)
        begin
            if (hole2_reg)
            begin
                total_reg  <= total_reg + TOT_W'(sq2_reg) * TOT_W'(HOLE_WEIGHT);
                weight_reg <= weight_reg + WSUM_W'(HOLE_WEIGHT);
            end
            else
            begin
                total_reg  <= total_reg + TOT_W'(sq2_reg) * TOT_W'(KNOWN_WEIGHT);
                weight_reg <= weight_reg + WSUM_W'(KNOWN_WEIGHT);
            end
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign div_start = (state_reg == ST_DRAIN) && drained && !div_busy;
    assign total     = total_reg;
    assign weight    = weight_reg;

endmodule

### design/wpd_div.sv
// Restoring divider, one quotient bit per cycle.
module wpd_div #(
    parameter int TOT_W  = 28,
    parameter int WSUM_W = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [TOT_W-1:0]           dividend,
    input  logic [WSUM_W-1:0]          divisor,
    output logic                       busy,
    output logic                       done,
    output logic [wpd_pkg::DIST_W-1:0] quotient
);
    import wpd_pkg::*;

    localparam int CNT_W = $clog2(TOT_W + 1);

    logic                busy_reg, done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [TOT_W-1:0]    q_reg, q_next;
    logic [WSUM_W-1:0]   rem_reg, rem_next, divisor_reg;
    logic [DIST_W-1:0]   quotient_reg;
    logic [WSUM_W:0]     trial, diff;
    logic                fits;

    always_comb
    begin
        trial    = {rem_reg, q_reg[TOT_W-1]};
        diff     = trial - {1'b0, divisor_reg};
        fits     = (trial >= {1'b0, divisor_reg});
        rem_next = fits ? diff[WSUM_W-1:0] : trial[WSUM_W-1:0];
        q_next   = {q_reg[TOT_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(TOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            q_reg       <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
            if (cnt_reg == CNT_W'(1))
            begin
                quotient_reg <= q_next[DIST_W-1:0];
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quotient_reg;

endmodule

### design/wpd_check.sv
// Port-level checks for the weighted patch distance block, bound to the top level.
module wpd_check (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       op,
    input logic                       done,
    input logic [wpd_pkg::DIST_W-1:0] distance
);
    import wpd_pkg::*;

    localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(MAX_SQ);

    write_stays_free: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == OP_WRITE) |=> !busy)
        else $error("write request raised busy");

    dist_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == OP_DIST) |=> busy)
        else $error("distance request did not raise busy");

    busy_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && op == OP_DIST))
        else $error("busy rose without a distance request");

    done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    done_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (distance <= DIST_MAX))
        else $error("distance above maximum");

endmodule

bind weighted_patch_distance_top wpd_check u_wpd_check (.*);

### bench/tb_weighted_patch_distance_top.sv
// Self-checking bench for the weighted patch distance block: store preload, directed table, random phases.
module tb_weighted_patch_distance_top;
    timeunit 1ns;
    timeprecision 1ps;
    import wpd_pkg::*;

    localparam int STORE_W = DEF_MAX_WIDTH;
    localparam int STORE_H = DEF_MAX_HEIGHT;
    localparam int COORD_MAX = (1 << COORD_W) - 1;
    localparam int CFG_MAX = (1 << CFG_W) - 1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT = 3000;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 110;
    localparam int QUIET_PHASES = 2;
    localparam int PRE_W = 32;
    localparam int PRE_H = 32;
    localparam int PICK_TRIES = 32;

    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] tc;
        logic [COORD_W-1:0] tr;
        logic [COORD_W-1:0] sc;
        logic [COORD_W-1:0] sr;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               hole;
    } pixel_req_t;

    localparam int REQ_W = $bits(pixel_req_t);

    typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t            kind;
        pixel_req_t           req;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     val;
        bit                   typed;
        logic [DIST_W-1:0]    want;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 op;
    logic [COORD_W-1:0]   target_col;
    logic [COORD_W-1:0]   target_row;
    logic [COORD_W-1:0]   source_col;
    logic [COORD_W-1:0]   source_row;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;
    logic                 hole_mark;
    logic                 done;
    logic [DIST_W-1:0]    distance;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0]     cfg_data;

    logic [PIX_W-1:0]  pix_mem [STORE_W*STORE_H];
    bit                seen [STORE_W*STORE_H];
    logic [CFG_W-1:0]  frame_w_cfg;
    logic [CFG_W-1:0]  frame_h_cfg;
    logic [RAD_W-1:0]  radius_cfg;
    logic [DIST_W-1:0] pending_dist [$];
    logic [DIST_W-1:0] want_dist;
    stim_row_t         rows [$];

    int errors = 0;
    int stall_cycles = 0;
    int n_writes = 0;
    int n_dists = 0;
    int n_results = 0;
    int n_cfg = 0;

    weighted_patch_distance_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .target_col (target_col),
        .target_row (target_row),
        .source_col (source_col),
        .source_row (source_row),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .hole_mark  (hole_mark),
        .done       (done),
        .distance   (distance),
        .cfg_write  (cfg_write),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int eff_dim(logic [CFG_W-1:0] v, int max_dim);
        if (v == 0)
            return 1;
        return (int'(v) > max_dim) ? max_dim : int'(v);
    endfunction

    function automatic int clamp_int(int v, int hi);
        if (v < 0)
            return 0;
        return (v > hi) ? hi : v;
    endfunction

    function automatic int rgb_sq(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
        int sum;
        int d;
        sum = 0;
        for (int c = 0; c < 3; c++)
        begin
            d = int'(a[8*c +: 8]) - int'(b[8*c +: 8]);
            sum += d * d;
        end
        return sum;
    endfunction

    function automatic logic [DIST_W-1:0] predict_distance(pixel_req_t q);
        int w;
        int h;
        int r;
        int tx;
        int ty;
        int sx;
        int sy;
        int wt;
        logic [PIX_W-1:0] tp;
        logic [PIX_W-1:0] sp;
        longint unsigned acc;
        longint unsigned wsum;
        w = eff_dim(frame_w_cfg, STORE_W);
        h = eff_dim(frame_h_cfg, STORE_H);
        r = int'(radius_cfg);
        acc = 0;
        wsum = 0;
        for (int dy = -r; dy <= r; dy++)
        begin
            ty = clamp_int(int'(q.tr) + dy, h - 1);
            sy = int'(q.sr) + dy;
            for (int dx = -r; dx <= r; dx++)
            begin
                tx = clamp_int(int'(q.tc) + dx, w - 1);
                sx = int'(q.sc) + dx;
                tp = pix_mem[ty*STORE_W + tx];
                if (sx < 0 || sy < 0 || sx >= w || sy >= h)
                    sp = '0;
                else
                    sp = pix_mem[sy*STORE_W + sx];
                wt = tp[HOLE_BIT] ? HOLE_WEIGHT : KNOWN_WEIGHT;
                acc += longint'(wt) * longint'(rgb_sq(tp, sp));
                wsum += wt;
            end
        end
        return DIST_W'(acc / wsum);
    endfunction

    // true when every pixel the patch pair reads has been written
    function automatic bit reads_written(pixel_req_t q);
        int w;
        int h;
        int r;
        int tx;
        int ty;
        int sx;
        int sy;
        w = eff_dim(frame_w_cfg, STORE_W);
        h = eff_dim(frame_h_cfg, STORE_H);
        r = int'(radius_cfg);
        for (int dy = -r; dy <= r; dy++)
        begin
            for (int dx = -r; dx <= r; dx++)
            begin
                ty = clamp_int(int'(q.tr) + dy, h - 1);
                tx = clamp_int(int'(q.tc) + dx, w - 1);
                sy = int'(q.sr) + dy;
                sx = int'(q.sc) + dx;
                if (!seen[ty*STORE_W + tx])
                    return 1'b0;
                if (sx >= 0 && sy >= 0 && sx < w && sy < h && !seen[sy*STORE_W + sx])
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic int pick_coord(int lim);
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, COORD_MAX);
            1: return lim - 1 - $urandom_range(0, (lim > 8) ? 8 : lim - 1);
            default: return $urandom_range(0, lim - 1);
        endcase
    endfunction

    function automatic int pick_dim();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 1;
            2: return STORE_W;
            3: return $urandom_range(STORE_W + 1, CFG_MAX);
            default: return $urandom_range(2, STORE_W - 1);
        endcase
    endfunction

    function automatic pixel_req_t random_request();
        pixel_req_t q;
        int w;
        int h;
        int lw;
        int lh;
        w = eff_dim(frame_w_cfg, STORE_W);
        h = eff_dim(frame_h_cfg, STORE_H);
        lw = (w < PRE_W) ? w : PRE_W;
        lh = (h < PRE_H) ? h : PRE_H;
        q = REQ_W'({$urandom, $urandom});
        q.op = ($urandom_range(0, 9) < 4) ? OP_WRITE : OP_DIST;
        if (q.op == OP_DIST)
        begin
            for (int t = 0; t < PICK_TRIES; t++)
            begin
                q.tc = COORD_W'(pick_coord(lw));
                q.tr = COORD_W'(pick_coord(lh));
                if ($urandom_range(0, 7) == 0)
                begin
                    q.sc = q.tc;
                    q.sr = q.tr;
                end
                else
                begin
                    q.sc = COORD_W'(pick_coord(lw));
                    q.sr = COORD_W'(pick_coord(lh));
                end
                if (reads_written(q))
                    return q;
            end
            q.op = OP_WRITE;
        end
        if ($urandom_range(0, 1) == 1)
        begin
            q.tc = COORD_W'($urandom_range(0, w - 1));
            q.tr = COORD_W'($urandom_range(0, h - 1));
        end
        q.hole = ($urandom_range(0, 3) == 0);
        return q;
    endfunction

    function automatic stim_row_t req_row(logic o, int tc, int tr, int sc, int sr, int rd,
                                          int gr, int bl, int hl, bit typed = 1'b0,
                                          int want = 0);
        stim_row_t row;
        row.kind = ROW_REQ;
        row.req = '{o, COORD_W'(tc), COORD_W'(tr), COORD_W'(sc), COORD_W'(sr),
                    COLOR_W'(rd), COLOR_W'(gr), COLOR_W'(bl), 1'(hl)};
        row.idx = '0;
        row.val = '0;
        row.typed = typed;
        row.want = DIST_W'(want);
        return row;
    endfunction

    function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int val);
        stim_row_t row;
        row.kind = ROW_CFG;
        row.req = '0;
        row.idx = idx;
        row.val = CFG_W'(val);
        row.typed = 1'b0;
        row.want = '0;
        return row;
    endfunction

    function automatic void add_row(stim_row_t row);
        rows.insert(rows.size(), row);
    endfunction

    task automatic report(string line);
        $display("%0t ns: %s", $time, line);
        errors++;
    endtask

    // drive one request and hold it until taken; the caller decides whether start drops
    task automatic put_request(pixel_req_t q, bit typed = 1'b0,
                               logic [DIST_W-1:0] typed_dist = '0);
        start      <= 1'b1;
        op         <= q.op;
        target_col <= q.tc;
        target_row <= q.tr;
        source_col <= q.sc;
        source_row <= q.sr;
        red        <= q.red;
        green      <= q.green;
        blue       <= q.blue;
        hole_mark  <= q.hole;
        do
            @(posedge clk);
        while (busy);
        if (q.op == OP_WRITE)
        begin
            pix_mem[int'(q.tr)*STORE_W + int'(q.tc)] = {q.hole, q.red, q.green, q.blue};
            seen[int'(q.tr)*STORE_W + int'(q.tc)] = 1'b1;
            n_writes++;
        end
        else
        begin
            pending_dist.insert(pending_dist.size(), typed ? typed_dist : predict_distance(q));
            n_dists++;
        end
    endtask

    task automatic idle(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        start <= 1'b0;
        while (pending_dist.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_FRAME_WIDTH:  frame_w_cfg = val;
            CFG_FRAME_HEIGHT: frame_h_cfg = val;
            CFG_PATCH_RADIUS: radius_cfg = val[RAD_W-1:0];
            default: ;
        endcase
        cfg_write <= 1'b0;
        n_cfg++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_dist.size() == 0)
                report($sformatf("distance %0d with no request waiting", distance));
            else
            begin
                want_dist = pending_dist.pop_front();
                n_results++;
                if (distance !== want_dist)
                    report($sformatf("distance expected %0d got %0d", want_dist, distance));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_write)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", stall_cycles);
            $display("Regression FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        pixel_req_t q;
        int fw;
        int fh;
        int pr;

        rst_n      <= 1'b0;
        start      <= 1'b0;
        op         <= OP_WRITE;
        target_col <= '0;
        target_row <= '0;
        source_col <= '0;
        source_row <= '0;
        red        <= '0;
        green      <= '0;
        blue       <= '0;
        hole_mark  <= 1'b0;
        cfg_write  <= 1'b0;
        cfg_addr   <= CFG_FRAME_WIDTH;
        cfg_data   <= '0;
        frame_w_cfg = FRAME_WIDTH_RST;
        frame_h_cfg = FRAME_HEIGHT_RST;
        radius_cfg  = PATCH_RADIUS_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the store is not cleared by reset: fill a corner block, distance reads stay on
        // written pixels
        for (int r = 0; r < PRE_H; r++)
            for (int c = 0; c < PRE_W; c++)
            begin
                q = REQ_W'({$urandom, $urandom});
                q.op = OP_WRITE;
                q.tc = COORD_W'(c);
                q.tr = COORD_W'(r);
                q.hole = ($urandom_range(0, 3) == 0);
                put_request(q);
            end

        // single pixel patches: white known vs black hole, both ways, and self match
        add_row(cfg_row(CFG_PATCH_RADIUS, 0));
        add_row(req_row(OP_WRITE, 10, 10, 255, 255, 255, 255, 255, 0));
        add_row(req_row(OP_WRITE, 20, 20, 0, 0, 0, 0, 0, 1));
        add_row(req_row(OP_DIST, 10, 10, 20, 20, 0, 0, 0, 0, 1'b1, MAX_SQ));
        add_row(req_row(OP_DIST, 20, 20, 10, 10, 255, 255, 255, 1, 1'b1, MAX_SQ));
        add_row(req_row(OP_DIST, 10, 10, 10, 10, 0, 0, 0, 0, 1'b1, 0));
        add_row(req_row(OP_WRITE, 255, 255, 0, 0, 255, 0, 255, 1));
        add_row(req_row(OP_WRITE, 254, 255, 0, 0, 0, 128, 64, 0));
        add_row(req_row(OP_WRITE, 255, 254, 0, 0, 32, 0, 200, 1));
        add_row(req_row(OP_WRITE, 254, 254, 0, 0, 90, 90, 90, 0));
        add_row(req_row(OP_WRITE, 0, 0, 255, 255, 0, 255, 0, 0));
        // widest patch: target clamps at the top and left edges, source leaves the frame
        add_row(cfg_row(CFG_PATCH_RADIUS, 7));
        add_row(req_row(OP_DIST, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(req_row(OP_DIST, 16, 16, 16, 16, 0, 0, 0, 0, 1'b1, 0));
        add_row(req_row(OP_DIST, 0, 24, 24, 0, 0, 0, 0, 0));
        // zero size acts as one pixel
        add_row(cfg_row(CFG_FRAME_WIDTH, 0));
        add_row(cfg_row(CFG_FRAME_HEIGHT, 0));
        add_row(req_row(OP_DIST, 200, 100, 0, 0, 0, 0, 0, 0));
        // oversize saturates to the store size, far corner clamps; unused index is ignored
        add_row(cfg_row(CFG_PATCH_RADIUS, 1));
        add_row(cfg_row(CFG_FRAME_WIDTH, CFG_MAX));
        add_row(cfg_row(CFG_FRAME_HEIGHT, 300));
        add_row(req_row(OP_DIST, 255, 255, 255, 255, 0, 0, 0, 0));
        add_row(req_row(OP_DIST, 255, 255, 0, 0, 0, 0, 0, 0));
        add_row(cfg_row(CFG_UNUSED, CFG_MAX));
        add_row(req_row(OP_DIST, 3, 3, 7, 9, 0, 0, 0, 0));
        // small frame
        add_row(cfg_row(CFG_FRAME_WIDTH, 16));
        add_row(cfg_row(CFG_FRAME_HEIGHT, 8));
        add_row(req_row(OP_DIST, 15, 7, 14, 6, 0, 0, 0, 0));
        add_row(req_row(OP_DIST, 3, 3, 20, 20, 0, 0, 0, 0));
        add_row(req_row(OP_WRITE, 15, 7, 255, 255, 255, 255, 255, 1));
        add_row(req_row(OP_DIST, 15, 7, 14, 6, 0, 0, 0, 0));
        add_row(req_row(OP_DIST, 255, 255, 15, 7, 0, 0, 0, 0));

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
                write_reg(rows[i].idx, rows[i].val);
            else
                put_request(rows[i].req, rows[i].typed, rows[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    fw = 1;
                    fh = 1;
                    pr = 0;
                end
                1:
                begin
                    fw = STORE_W;
                    fh = STORE_H;
                    pr = DEF_MAX_RADIUS;
                end
                2:
                begin
                    fw = 0;
                    fh = CFG_MAX;
                    pr = 1;
                end
                default:
                begin
                    fw = pick_dim();
                    fh = pick_dim();
                    pr = $urandom_range(0, DEF_MAX_RADIUS);
                end
            endcase
            write_reg(CFG_FRAME_WIDTH, CFG_W'(fw));
            write_reg(CFG_FRAME_HEIGHT, CFG_W'(fh));
            write_reg(CFG_PATCH_RADIUS, CFG_W'(pr));
            write_reg(CFG_UNUSED, CFG_W'($urandom_range(0, CFG_MAX)));
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                put_request(random_request());
                if (p < PHASES - QUIET_PHASES && $urandom_range(0, 2) == 0)
                    idle($urandom_range(1, 13));
            end
        end

        start <= 1'b0;
        while (pending_dist.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d pixel writes and %0d distance requests, %0d distances checked",
                 n_writes, n_dists, n_results);
        $display("%0d register writes across %0d frame size and radius settings",
                 n_cfg, PHASES);
        if (errors == 0 && pending_dist.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
